### src/pimu_pkg.sv
`default_nettype none

package pimu_pkg;

    // default sizes
    localparam int NUM_TASKS_DEF     = 16;
    localparam int NUM_MUTEXES_DEF   = 8;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam int HOLD_BITS_DEF     = 8;

    // results per request, priority-change results stop one short of it
    localparam int MAX_RESULTS = 10;

    // stream payload widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // request opcodes
    localparam logic [1:0] OP_ACQUIRE  = 2'd0;
    localparam logic [1:0] OP_RELEASE  = 2'd1;
    localparam logic [1:0] OP_SET_BASE = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_PRIO  = 2'd0;
    localparam logic [1:0] KIND_WOKEN = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // done status codes
    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_BLOCKED  = 3'd1;
    localparam logic [2:0] ST_HELD     = 3'd2;
    localparam logic [2:0] ST_FREED    = 3'd3;
    localparam logic [2:0] ST_HANDED   = 3'd4;
    localparam logic [2:0] ST_REJECTED = 3'd5;
    localparam logic [2:0] ST_BASE_SET = 3'd6;

endpackage

`default_nettype wire

### src/priority_inheritance_mutex_unit.sv
// path from the accepting cycle to the done transfer: set-base and rejected requests,
//   grants and partial releases need no scan, a blocking acquire first counts the waiters
//   queued on the mutex and then walks the owner chain mutex by mutex, and a full release
//   scans the mutexes and then the tasks, and on hand-over scans the tasks once more
// throughput: one request at a time, the next is taken once the done result is registered
// reset: rst_n asynchronous active low, all mutexes free, no task waiting, priorities zero
`default_nettype none

module priority_inheritance_mutex_unit
    import pimu_pkg::*;
#(
    parameter int NUM_TASKS     = NUM_TASKS_DEF,
    parameter int NUM_MUTEXES   = NUM_MUTEXES_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
    parameter int HOLD_BITS     = HOLD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // opcode[1:0], task_id[5:2], mutex_id[8:6], base_priority[16:9], zero pad above
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // kind[1:0], target_task[5:2], new_priority[13:6], status[16:14], zero pad above
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast
);

    localparam int TW = $clog2(NUM_TASKS);
    localparam int MW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int PW = PRIORITY_BITS;
    localparam int HW = HOLD_BITS;
    localparam int CW = ((TW > MW) ? TW : MW) + 1;
    localparam logic [HW-1:0] HOLD_MAX = {HW{1'b1}};
    localparam logic [3:0] CHG_LIMIT = 4'(MAX_RESULTS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_ACQ, S_CNT, S_CH_M, S_CH_O, S_CH_P, S_CH_E, S_CH_W,
        S_REL, S_RS_M, S_RS_T, S_RS_E, S_RK, S_RH, S_FIN, S_FIN_E
    } state_t;

    // request fields
    logic [1:0] in_op;
    logic [3:0] in_task;
    logic [2:0] in_mutex;
    logic [7:0] in_prio;
    assign in_op    = s_axis_tdata[1:0];
    assign in_task  = s_axis_tdata[5:2];
    assign in_mutex = s_axis_tdata[8:6];
    assign in_prio  = s_axis_tdata[16:9];

    // task priority table {current, base}, waiter table {mutex, rank}, mutex table {owner, hold}
    logic [2*PW-1:0]  amem [NUM_TASKS];
    logic [MW+TW-1:0] bmem [NUM_TASKS];
    logic [TW+HW-1:0] mmem [NUM_MUTEXES];

    logic [2*PW-1:0]  a_rdata_reg;
    logic             a_vld_reg;
    logic [MW+TW-1:0] b_rdata_reg;
    logic [TW+HW-1:0] m_rdata_reg;

    logic [TW-1:0]    a_raddr, a_waddr, b_raddr, b_waddr, m_wown;
    logic [MW-1:0]    m_raddr, m_waddr;
    logic             a_we, b_we, m_we;
    logic [2*PW-1:0]  a_wdata;
    logic [MW+TW-1:0] b_wdata;
    logic [HW-1:0]    m_whold;

    // control and working registers
    state_t state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic [TW-1:0] t_reg, t_next;
    logic [3:0]  tgt_reg, tgt_next;
    logic [MW-1:0] m_reg, m_next;
    logic [PW-1:0] p_reg, p_next;
    logic        bad_t_reg, bad_t_next, bad_m_reg, bad_m_next;
    logic [2:0]  status_reg, status_next;
    logic [MW-1:0] cm_reg, cm_next;
    logic [PW-1:0] cprio_reg, cprio_next;
    logic [TW-1:0] o_reg, o_next;
    logic [NUM_MUTEXES-1:0] seen_reg, seen_next, held_reg, held_next, ov_reg, ov_next;
    logic [3:0]  chg_reg, chg_next;
    logic        emit_pend_reg, emit_pend_next;
    logic [TW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] cur_t_reg, cur_t_next, base_t_reg, base_t_next, target_reg, target_next;
    logic        bf_reg, bf_next;
    logic [TW-1:0] best_reg, best_next, brank_reg, brank_next;
    logic [PW-1:0] bcur_reg, bcur_next;
    logic [CW-1:0] sidx_reg, sidx_next;
    logic [CW-2:0] pidx_reg, pidx_next;
    logic        pend_reg, pend_next;
    logic [NUM_TASKS-1:0] wv_reg, wv_next, ainit_reg, ainit_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  o_kind_reg, o_kind_next;
    logic [3:0]  o_task_reg, o_task_next;
    logic [7:0]  o_prio_reg, o_prio_next;
    logic [2:0]  o_stat_reg, o_stat_next;
    logic        o_last_reg, o_last_next;

    // read data views
    logic [PW-1:0] a_cur, a_base;
    logic [MW-1:0] b_wm;
    logic [TW-1:0] b_rank, pidx_t, m_owner;
    logic [MW-1:0] pidx_m;
    logic [HW-1:0] m_hold, hold_dec;
    logic          out_free, scan_t_issue, scan_m_issue;

    assign a_cur    = a_vld_reg ? a_rdata_reg[2*PW-1:PW] : '0;
    assign a_base   = a_vld_reg ? a_rdata_reg[PW-1:0] : '0;
    assign b_wm     = b_rdata_reg[MW+TW-1:TW];
    assign b_rank   = b_rdata_reg[TW-1:0];
    assign m_owner  = m_rdata_reg[TW+HW-1:HW];
    assign m_hold   = m_rdata_reg[HW-1:0];
    assign hold_dec = m_hold - HW'(1);
    assign pidx_t   = pidx_reg[TW-1:0];
    assign pidx_m   = pidx_reg[MW-1:0];
    assign out_free = !out_valid_reg || m_axis_tready;
    assign scan_t_issue = sidx_reg < CW'(NUM_TASKS);
    assign scan_m_issue = sidx_reg < CW'(NUM_MUTEXES);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tdata  = {7'd0, o_stat_reg, o_prio_reg, o_task_reg, o_kind_reg};

    // memories, one read and one write port each
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            amem[a_waddr] <= a_wdata;
        end
        a_rdata_reg <= amem[a_raddr];
        a_vld_reg   <= ainit_reg[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            bmem[b_waddr] <= b_wdata;
        end
        b_rdata_reg <= bmem[b_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            mmem[m_waddr] <= {m_wown, m_whold};
        end
        m_rdata_reg <= mmem[m_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg; t_next = t_reg; tgt_next = tgt_reg; m_next = m_reg; p_next = p_reg;
        bad_t_next = bad_t_reg; bad_m_next = bad_m_reg; status_next = status_reg;
        cm_next = cm_reg; cprio_next = cprio_reg; o_next = o_reg; seen_next = seen_reg;
        held_next = held_reg; ov_next = ov_reg; chg_next = chg_reg;
        emit_pend_next = emit_pend_reg; cnt_next = cnt_reg; cur_t_next = cur_t_reg;
        base_t_next = base_t_reg; target_next = target_reg; bf_next = bf_reg;
        best_next = best_reg; brank_next = brank_reg; bcur_next = bcur_reg;
        sidx_next = sidx_reg; pidx_next = pidx_reg; pend_next = pend_reg;
        wv_next = wv_reg; ainit_next = ainit_reg;

        out_valid_next = out_valid_reg && !m_axis_tready;
        o_kind_next = o_kind_reg; o_task_next = o_task_reg; o_prio_next = o_prio_reg;
        o_stat_next = o_stat_reg; o_last_next = o_last_reg;

        // reads default to the requester and its mutex
        a_raddr = t_reg; b_raddr = t_reg; m_raddr = m_reg;
        a_we = 1'b0; a_waddr = t_reg; a_wdata = '0;
        b_we = 1'b0; b_waddr = t_reg; b_wdata = '0;
        m_we = 1'b0; m_waddr = m_reg; m_wown = t_reg; m_whold = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = in_op;
                    tgt_next   = in_task;
                    t_next     = TW'(in_task);
                    m_next     = MW'(in_mutex);
                    p_next     = PW'(in_prio);
                    bad_t_next = 32'(in_task) >= NUM_TASKS;
                    bad_m_next = 32'(in_mutex) >= NUM_MUTEXES;
                    chg_next   = '0;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_FIN;
                if (bad_t_reg)
                begin
                    status_next = ST_REJECTED;
                end
                else if (op_reg == OP_SET_BASE)
                begin
                    a_we = 1'b1;
                    a_wdata = {p_reg, p_reg};
                    ainit_next[t_reg] = 1'b1;
                    status_next = ST_BASE_SET;
                end
                else if (bad_m_reg || (op_reg != OP_ACQUIRE && op_reg != OP_RELEASE))
                begin
                    status_next = ST_REJECTED;
                end
                else if (op_reg == OP_ACQUIRE)
                begin
                    if (wv_reg[t_reg])
                    begin
                        status_next = ST_BLOCKED;
                    end
                    else if (!ov_reg[m_reg])
                    begin
                        m_we = 1'b1;
                        m_whold = HW'(1);
                        ov_next[m_reg] = 1'b1;
                        status_next = ST_GRANTED;
                    end
                    else
                    begin
                        state_next = S_ACQ;
                    end
                end
                else if (!ov_reg[m_reg])
                begin
                    status_next = ST_REJECTED;
                end
                else
                begin
                    state_next = S_REL;
                end
            end
            S_ACQ:
            begin
                if (m_owner == t_reg)
                begin
                    // recursive acquire, count saturates
                    m_we = 1'b1;
                    if (m_hold == '0)
                    begin
                        m_whold = HW'(1);
                    end
                    else if (m_hold != HOLD_MAX)
                    begin
                        m_whold = m_hold + HW'(1);
                    end
                    else
                    begin
                        m_whold = m_hold;
                    end
                    status_next = ST_GRANTED;
                    state_next  = S_FIN;
                end
                else
                begin
                    cprio_next  = a_cur;
                    cnt_next    = '0;
                    sidx_next   = '0;
                    pend_next   = 1'b0;
                    status_next = ST_BLOCKED;
                    state_next  = S_CNT;
                end
            end
            S_CNT:
            begin
                // count waiters already queued on this mutex
                b_raddr   = sidx_reg[TW-1:0];
                pend_next = scan_t_issue;
                pidx_next = sidx_reg[CW-2:0];
                if (scan_t_issue)
                begin
                    sidx_next = sidx_reg + CW'(1);
                end
                if (pend_reg && wv_reg[pidx_t] && b_wm == m_reg)
                begin
                    cnt_next = cnt_reg + TW'(1);
                end
                if (!scan_t_issue && !pend_reg)
                begin
                    b_we = 1'b1;
                    b_wdata = {m_reg, cnt_reg};
                    wv_next[t_reg] = 1'b1;
                    cm_next   = m_reg;
                    seen_next = '0;
                    state_next = S_CH_M;
                end
            end
            S_CH_M:
            begin
                m_raddr = cm_reg;
                if (seen_reg[cm_reg] || !ov_reg[cm_reg])
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    seen_next[cm_reg] = 1'b1;
                    state_next = S_CH_O;
                end
            end
            S_CH_O:
            begin
                o_next  = m_owner;
                a_raddr = m_owner;
                state_next = S_CH_P;
            end
            S_CH_P:
            begin
                emit_pend_next = 1'b0;
                if (a_cur < cprio_reg)
                begin
                    a_we = 1'b1;
                    a_waddr = o_reg;
                    a_wdata = {cprio_reg, a_base};
                    ainit_next[o_reg] = 1'b1;
                    emit_pend_next = chg_reg < CHG_LIMIT;
                end
                else
                begin
                    cprio_next = a_cur;
                end
                state_next = S_CH_E;
            end
            S_CH_E:
            begin
                b_raddr = o_reg;
                if (!emit_pend_reg || out_free)
                begin
                    if (emit_pend_reg)
                    begin
                        out_valid_next = 1'b1;
                        o_kind_next = KIND_PRIO;
                        o_task_next = 4'(o_reg);
                        o_prio_next = 8'(cprio_reg);
                        o_stat_next = '0;
                        o_last_next = 1'b0;
                        chg_next = chg_reg + 4'd1;
                    end
                    emit_pend_next = 1'b0;
                    state_next = wv_reg[o_reg] ? S_CH_W : S_FIN;
                end
            end
            S_CH_W:
            begin
                cm_next = b_wm;
                state_next = S_CH_M;
            end
            S_REL:
            begin
                cur_t_next  = a_cur;
                base_t_next = a_base;
                target_next = a_base;
                held_next   = '0;
                sidx_next   = '0;
                pend_next   = 1'b0;
                if (m_owner != t_reg)
                begin
                    status_next = ST_REJECTED;
                    state_next  = S_FIN;
                end
                else if (m_hold != '0 && hold_dec != '0)
                begin
                    m_we = 1'b1;
                    m_whold = hold_dec;
                    status_next = ST_HELD;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_RS_M;
                end
            end
            S_RS_M:
            begin
                // mark the other mutexes this task owns
                m_raddr   = sidx_reg[MW-1:0];
                pend_next = scan_m_issue;
                pidx_next = sidx_reg[CW-2:0];
                if (scan_m_issue)
                begin
                    sidx_next = sidx_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    held_next[pidx_m] = ov_reg[pidx_m] && m_owner == t_reg && pidx_m != m_reg;
                end
                if (!scan_m_issue && !pend_reg)
                begin
                    sidx_next  = '0;
                    bf_next    = 1'b0;
                    state_next = S_RS_T;
                end
            end
            S_RS_T:
            begin
                // restore target and best waiter in one pass over the tasks
                a_raddr   = sidx_reg[TW-1:0];
                b_raddr   = sidx_reg[TW-1:0];
                pend_next = scan_t_issue;
                pidx_next = sidx_reg[CW-2:0];
                if (scan_t_issue)
                begin
                    sidx_next = sidx_reg + CW'(1);
                end
                if (pend_reg && wv_reg[pidx_t])
                begin
                    if (held_reg[b_wm] && a_cur > target_reg)
                    begin
                        target_next = a_cur;
                    end
                    if (b_wm == m_reg && (!bf_reg || a_cur > bcur_reg ||
                        (a_cur == bcur_reg && b_rank < brank_reg)))
                    begin
                        bf_next    = 1'b1;
                        best_next  = pidx_t;
                        bcur_next  = a_cur;
                        brank_next = b_rank;
                    end
                end
                if (!scan_t_issue && !pend_reg)
                begin
                    state_next = S_RS_E;
                end
            end
            S_RS_E:
            begin
                if (cur_t_reg == target_reg || out_free)
                begin
                    if (cur_t_reg != target_reg)
                    begin
                        a_we = 1'b1;
                        a_wdata = {target_reg, base_t_reg};
                        ainit_next[t_reg] = 1'b1;
                        out_valid_next = 1'b1;
                        o_kind_next = KIND_PRIO;
                        o_task_next = tgt_reg;
                        o_prio_next = 8'(target_reg);
                        o_stat_next = '0;
                        o_last_next = 1'b0;
                    end
                    sidx_next = '0;
                    pend_next = 1'b0;
                    if (bf_reg)
                    begin
                        state_next = S_RK;
                    end
                    else
                    begin
                        m_we = 1'b1;
                        m_wown = '0;
                        ov_next[m_reg] = 1'b0;
                        status_next = ST_FREED;
                        state_next  = S_FIN;
                    end
                end
            end
            S_RK:
            begin
                // close the gap the new owner leaves in the queue
                b_raddr   = sidx_reg[TW-1:0];
                pend_next = scan_t_issue;
                pidx_next = sidx_reg[CW-2:0];
                if (scan_t_issue)
                begin
                    sidx_next = sidx_reg + CW'(1);
                end
                if (pend_reg && wv_reg[pidx_t] && b_wm == m_reg && b_rank > brank_reg)
                begin
                    b_we = 1'b1;
                    b_waddr = pidx_t;
                    b_wdata = {b_wm, b_rank - TW'(1)};
                end
                if (!scan_t_issue && !pend_reg)
                begin
                    state_next = S_RH;
                end
            end
            S_RH:
            begin
                if (out_free)
                begin
                    wv_next[best_reg] = 1'b0;
                    b_we = 1'b1;
                    b_waddr = best_reg;
                    b_wdata = '0;
                    m_we = 1'b1;
                    m_wown = best_reg;
                    out_valid_next = 1'b1;
                    o_kind_next = KIND_WOKEN;
                    o_task_next = 4'(best_reg);
                    o_prio_next = 8'(bcur_reg);
                    o_stat_next = '0;
                    o_last_next = 1'b0;
                    status_next = ST_HANDED;
                    state_next  = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_FIN_E;
            end
            S_FIN_E:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_kind_next = KIND_DONE;
                    o_task_next = tgt_reg;
                    o_prio_next = bad_t_reg ? 8'd0 : 8'(a_cur);
                    o_stat_next = status_reg;
                    o_last_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ov_reg        <= '0;
            wv_reg        <= '0;
            ainit_reg     <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            emit_pend_reg <= 1'b0;
            chg_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ov_reg        <= ov_next;
            wv_reg        <= wv_next;
            ainit_reg     <= ainit_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            emit_pend_reg <= emit_pend_next;
            chg_reg       <= chg_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        op_reg <= op_next; t_reg <= t_next; tgt_reg <= tgt_next; m_reg <= m_next;
        p_reg <= p_next; bad_t_reg <= bad_t_next; bad_m_reg <= bad_m_next;
        status_reg <= status_next; cm_reg <= cm_next; cprio_reg <= cprio_next;
        o_reg <= o_next; seen_reg <= seen_next; held_reg <= held_next;
        cnt_reg <= cnt_next; cur_t_reg <= cur_t_next; base_t_reg <= base_t_next;
        target_reg <= target_next; bf_reg <= bf_next; best_reg <= best_next;
        brank_reg <= brank_next; bcur_reg <= bcur_next; sidx_reg <= sidx_next;
        pidx_reg <= pidx_next;
        o_kind_reg <= o_kind_next; o_task_reg <= o_task_next; o_prio_reg <= o_prio_next;
        o_stat_reg <= o_stat_next; o_last_reg <= o_last_next;
    end

`ifndef ASSERT_OFF
    // the done result is the only one marked last
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == KIND_DONE)))
        else $error("last flag does not match result kind");

    // the chain never reports more changes than the result budget allows
    assert property (@(posedge clk) disable iff (!rst_n)
        chg_reg <= CHG_LIMIT)
        else $error("priority change results over budget");

    // a new request is only taken once the previous done transfer is registered
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN_E && state_next == S_IDLE) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("done result missing at end of request");
`endif

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import pimu_pkg::*;

    // unused opcode, must be answered as rejected
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int N_TASKS  = 16;
    localparam int N_LOCKS  = 8;
    localparam int DEPTH_MAX = 255;
    localparam int RANDOM_ITEMS = 165;
    localparam int SATURATE_ITEMS = 258;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRESSURE_CYCLES = 400;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] target;
        logic [7:0] prio;
        logic [2:0] status;
        logic       last;
    } lock_result_t;

    typedef struct {
        logic [1:0] op;
        logic [3:0] tsk;
        logic [2:0] lock;
        logic [7:0] prio;
        bit         has_want;
        logic [2:0] want;
    } request_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    priority_inheritance_mutex_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // lock table and task table as the block should hold them
    bit          lock_owned [N_LOCKS];
    logic [3:0]  lock_owner [N_LOCKS];
    int          lock_depth [N_LOCKS];
    logic [7:0]  task_prio [N_TASKS];
    logic [7:0]  task_base [N_TASKS];
    bit          task_waits [N_TASKS];
    logic [2:0]  task_wait_lock [N_TASKS];
    int          task_rank [N_TASKS];

    // results still owed by the block, oldest first
    lock_result_t pending_results [$];
    int           results_this_request;
    logic [2:0]   predicted_status;

    int  mismatches = 0;
    int  cycles = 0;
    bit  random_phase = 0;

    request_row_t directed_rows [$];

    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // queue one result unless this request already used up its slots
    function automatic void note_result(logic [1:0] kind, int t, logic [2:0] status, bit last);
        lock_result_t r;
        if (results_this_request >= MAX_RESULTS)
            return;
        r.kind   = kind;
        r.target = t[3:0];
        r.prio   = task_prio[t];
        r.status = status;
        r.last   = last;
        pending_results = {pending_results, r};
        results_this_request++;
        if (kind == KIND_DONE)
            predicted_status = status;
    endfunction

    // priority changes keep one slot free for the done transfer
    function automatic void set_prio(int t, logic [7:0] p);
        task_prio[t] = p;
        if (results_this_request < MAX_RESULTS - 1)
            note_result(KIND_PRIO, t, ST_GRANTED, 1'b0);
    endfunction

    // walk the owner chain, each lock at most once
    function automatic void boost_chain(int m, logic [7:0] p);
        bit seen [N_LOCKS];
        int o;
        foreach (seen[i]) seen[i] = 0;
        forever
        begin
            if (seen[m]) return;
            seen[m] = 1;
            if (!lock_owned[m]) return;
            o = lock_owner[m];
            if (task_prio[o] < p) set_prio(o, p);
            if (!task_waits[o]) return;
            m = task_wait_lock[o];
            p = task_prio[o];
        end
    endfunction

    function automatic int waiter_total(int m);
        int n = 0;
        for (int t = 0; t < N_TASKS; t++)
            if (task_waits[t] && task_wait_lock[t] == m) n++;
        return n;
    endfunction

    // highest priority waiter, earliest queued on ties; N_TASKS when none
    function automatic int top_waiter(int m);
        int best = N_TASKS;
        for (int t = 0; t < N_TASKS; t++)
        begin
            if (!task_waits[t] || task_wait_lock[t] != m) continue;
            if (best == N_TASKS || task_prio[t] > task_prio[best] ||
                (task_prio[t] == task_prio[best] && task_rank[t] < task_rank[best]))
                best = t;
        end
        return best;
    endfunction

    // drop back to base or to the best waiter on the other locks still held
    function automatic void settle_prio(int t, int released);
        logic [7:0] goal = task_base[t];
        int w;
        for (int h = 0; h < N_LOCKS; h++)
        begin
            if (h == released || !lock_owned[h] || lock_owner[h] != t) continue;
            w = top_waiter(h);
            if (w < N_TASKS && task_prio[w] > goal) goal = task_prio[w];
        end
        if (task_prio[t] != goal) set_prio(t, goal);
    endfunction

    function automatic void model_acquire(int t, int m);
        if (task_waits[t])
        begin
            note_result(KIND_DONE, t, ST_BLOCKED, 1'b1);
            return;
        end
        if (!lock_owned[m])
        begin
            lock_owned[m] = 1;
            lock_owner[m] = t[3:0];
            lock_depth[m] = 1;
            note_result(KIND_DONE, t, ST_GRANTED, 1'b1);
            return;
        end
        if (lock_owner[m] == t)
        begin
            // recursive take, depth saturates
            if (lock_depth[m] == 0) lock_depth[m] = 1;
            else if (lock_depth[m] < DEPTH_MAX) lock_depth[m]++;
            note_result(KIND_DONE, t, ST_GRANTED, 1'b1);
            return;
        end
        task_rank[t] = waiter_total(m);
        task_wait_lock[t] = m[2:0];
        task_waits[t] = 1;
        boost_chain(m, task_prio[t]);
        note_result(KIND_DONE, t, ST_BLOCKED, 1'b1);
    endfunction

    function automatic void model_release(int t, int m);
        int nxt;
        if (!lock_owned[m] || lock_owner[m] != t)
        begin
            note_result(KIND_DONE, t, ST_REJECTED, 1'b1);
            return;
        end
        // a depth of zero after hand-over counts as a full release
        if (lock_depth[m] > 0)
        begin
            lock_depth[m]--;
            if (lock_depth[m] > 0)
            begin
                note_result(KIND_DONE, t, ST_HELD, 1'b1);
                return;
            end
        end
        settle_prio(t, m);
        nxt = top_waiter(m);
        if (nxt < N_TASKS)
        begin
            for (int u = 0; u < N_TASKS; u++)
                if (task_waits[u] && task_wait_lock[u] == m && task_rank[u] > task_rank[nxt])
                    task_rank[u]--;
            task_waits[nxt] = 0;
            task_wait_lock[nxt] = 0;
            task_rank[nxt] = 0;
            lock_owner[m] = nxt[3:0];
            lock_depth[m] = 0;
            note_result(KIND_WOKEN, nxt, ST_GRANTED, 1'b0);
            note_result(KIND_DONE, t, ST_HANDED, 1'b1);
        end
        else
        begin
            lock_owned[m] = 0;
            lock_owner[m] = 0;
            lock_depth[m] = 0;
            note_result(KIND_DONE, t, ST_FREED, 1'b1);
        end
    endfunction

    function automatic void predict_request(logic [1:0] op, logic [3:0] t, logic [2:0] m,
                                            logic [7:0] p);
        results_this_request = 0;
        case (op)
            OP_SET_BASE:
            begin
                task_base[t] = p;
                task_prio[t] = p;
                note_result(KIND_DONE, t, ST_BASE_SET, 1'b1);
            end
            OP_ACQUIRE: model_acquire(t, m);
            OP_RELEASE: model_release(t, m);
            default:    note_result(KIND_DONE, t, ST_REJECTED, 1'b1);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // mostly no gap, some short, a few long
    function automatic int gap_len();
        int r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // offer one request and hold it until the transfer, then predict it
    task automatic send_request(logic [1:0] op, logic [3:0] t, logic [2:0] m, logic [7:0] p);
        int gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, p, m, t, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_request(op, t, m, p);
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    // a long hold-off once the random part starts, so the block backs up
    initial
    begin
        int hold;
        int stall;
        bit pressure_done;
        hold = 0;
        stall = 0;
        pressure_done = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (random_phase && !pressure_done)
            begin
                pressure_done = 1;
                hold = PRESSURE_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                stall = gap_len();
                m_axis_tready <= 1'b1;
            end
        end
    end

    // compare every result transfer with the oldest outstanding one
    always @(posedge clk)
    begin
        lock_result_t got;
        lock_result_t exp_r;
        cycles <= cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind   = m_axis_tdata[1:0];
            got.target = m_axis_tdata[5:2];
            got.prio   = m_axis_tdata[13:6];
            got.status = m_axis_tdata[16:14];
            got.last   = m_axis_tlast;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d task=%0d prio=%0d status=%0d last=%0d",
                             got.kind, got.target, got.prio, got.status, got.last);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: exp kind=%0d task=%0d prio=%0d status=%0d",
                                  " last=%0d, got kind=%0d task=%0d prio=%0d status=%0d",
                                  " last=%0d"},
                                 exp_r.kind, exp_r.target, exp_r.prio, exp_r.status,
                                 exp_r.last, got.kind, got.target, got.prio, got.status,
                                 got.last);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[priority_inheritance_mutex_unit] ERROR");
            $finish;
        end
    end

    function automatic void add_row(logic [1:0] op, logic [3:0] t, logic [2:0] m, logic [7:0] p,
                                    bit has_want, logic [2:0] want);
        request_row_t r;
        r.op = op; r.tsk = t; r.lock = m; r.prio = p;
        r.has_want = has_want; r.want = want;
        directed_rows = {directed_rows, r};
    endfunction

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int pick;
        int m;
        logic [1:0] op;
        logic [3:0] t;

        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        foreach (lock_owned[i])
        begin
            lock_owned[i] = 0; lock_owner[i] = 0; lock_depth[i] = 0;
        end
        foreach (task_prio[i])
        begin
            task_prio[i] = 0; task_base[i] = 0; task_waits[i] = 0;
            task_wait_lock[i] = 0; task_rank[i] = 0;
        end

        // free lock after reset, extremes of priority, unused opcode, waiting
        // requester, foreign release, recursion, hand-over with tie on priority,
        // release at depth zero, chained inheritance
        add_row(OP_ACQUIRE,  0, 0,   0, 1, ST_GRANTED);
        add_row(OP_SET_BASE, 1, 0, 255, 1, ST_BASE_SET);
        add_row(OP_SET_BASE, 2, 0,   0, 1, ST_BASE_SET);
        add_row(OP_UNUSED,  15, 7, 255, 1, ST_REJECTED);
        add_row(OP_ACQUIRE,  1, 0,   0, 1, ST_BLOCKED);
        add_row(OP_ACQUIRE,  1, 1,   0, 1, ST_BLOCKED);
        add_row(OP_RELEASE,  3, 0,   0, 1, ST_REJECTED);
        add_row(OP_ACQUIRE,  0, 0,   0, 1, ST_GRANTED);
        add_row(OP_RELEASE,  0, 0,   0, 1, ST_HELD);
        add_row(OP_RELEASE,  0, 0,   0, 1, ST_HANDED);
        add_row(OP_SET_BASE, 4, 0, 100, 1, ST_BASE_SET);
        add_row(OP_ACQUIRE,  4, 7,   0, 1, ST_GRANTED);
        add_row(OP_SET_BASE, 5, 0, 200, 1, ST_BASE_SET);
        add_row(OP_ACQUIRE,  5, 7,   0, 1, ST_BLOCKED);
        add_row(OP_SET_BASE, 6, 0, 200, 1, ST_BASE_SET);
        add_row(OP_ACQUIRE,  6, 7,   0, 1, ST_BLOCKED);
        add_row(OP_RELEASE,  4, 7,   0, 1, ST_HANDED);
        add_row(OP_RELEASE,  5, 7,   0, 1, ST_HANDED);
        add_row(OP_SET_BASE, 11, 0, 250, 1, ST_BASE_SET);
        add_row(OP_ACQUIRE,  9, 3,   0, 1, ST_GRANTED);
        add_row(OP_ACQUIRE, 10, 4,   0, 1, ST_GRANTED);
        add_row(OP_ACQUIRE, 10, 3,   0, 1, ST_BLOCKED);
        add_row(OP_ACQUIRE, 11, 4,   0, 1, ST_BLOCKED);
        add_row(OP_RELEASE,  1, 0,   0, 1, ST_FREED);
        add_row(OP_SET_BASE, 15, 7, 128, 1, ST_BASE_SET);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].op, directed_rows[i].tsk, directed_rows[i].lock,
                         directed_rows[i].prio);
            if (directed_rows[i].has_want && predicted_status !== directed_rows[i].want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: done status should be %0d, prediction gives %0d",
                             i, directed_rows[i].want, predicted_status);
            end
        end

        random_phase = 1;

        // hold depth runs into saturation, then one release leaves it held
        repeat (SATURATE_ITEMS) send_request(OP_ACQUIRE, 12, 2, 0);
        send_request(OP_RELEASE, 12, 2, 0);

        // mostly meaningful traffic: releases by the real owner, acquires on any
        // of the eight locks, with priority updates and some noise mixed in
        repeat (RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            t = 4'($urandom_range(15));
            m = $urandom_range(7);
            if (pick < 40)
                op = OP_ACQUIRE;
            else if (pick < 75)
            begin
                op = OP_RELEASE;
                if ($urandom_range(9) < 8 && lock_owned[m])
                    t = lock_owner[m];
            end
            else if (pick < 95)
                op = OP_SET_BASE;
            else
                op = OP_UNUSED;
            send_request(op, t, m[2:0], 8'($urandom_range(255)));
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("[priority_inheritance_mutex_unit] OK");
        else
            $display("[priority_inheritance_mutex_unit] ERROR");
        $finish;
    end

endmodule
